FILE: src/plis_pkg.sv
`timescale 1ns / 1ps

package plis_pkg;

   // default list capacity
   localparam int DEPTH_DEFAULT = 64;

   // request commands
   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_DUMP   = 2'd3
   } plis_cmd_type;

   // response kinds
   localparam logic [2:0] KIND_OK       = 3'd0;
   localparam logic [2:0] KIND_FOUND    = 3'd1;
   localparam logic [2:0] KIND_ELEMENT  = 3'd2;
   localparam logic [2:0] KIND_NOTFOUND = 3'd3;
   localparam logic [2:0] KIND_EMPTY    = 3'd4;
   localparam logic [2:0] KIND_BADPOS   = 3'd5;
   localparam logic [2:0] KIND_FULL     = 3'd6;

   // sequencer states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } plis_state_type;

   // request payload
   typedef struct packed {
      plis_cmd_type       cmd;
      logic signed [31:0] value;
      logic [6:0]         position;
   } plis_req_type;

   // response payload
   typedef struct packed {
      logic [2:0]         kind;
      logic signed [31:0] data;
      logic               last;
   } plis_rsp_type;

endpackage

FILE: src/positional_list_insert_delete_search.sv
`timescale 1ns / 1ps

// channel   | ports                          | handshake
// ----------+--------------------------------+----------------------------------
// request   | start, busy, req_data          | taken at edge with start & !busy
// response  | rsp_strobe, rsp_data           | one cycle per response, no stall
//
// range errors, full list and empty dump answer in the cycle after the request.
// every other request walks L list entries through the single memory read
// port (insert: count-position+1, delete: count-position, search/dump: count)
// and keeps busy high until the walk drains and the request finishes.
// synchronous reset clears the count and the sequencer; the list contents
// are not cleared. responses cannot be held off by the receiver.

module positional_list_insert_delete_search #(
   parameter int DEPTH = plis_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  plis_pkg::plis_req_type req_data,
   output logic                  rsp_strobe,
   output plis_pkg::plis_rsp_type rsp_data
);

   import plis_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   plis_state_type     state_ff, state_in;
   plis_cmd_type       op_ff, op_in;
   logic signed [31:0] value_ff, value_in;
   logic [6:0]         pos_ff, pos_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      cursor_ff, cursor_in;
   logic [CW-1:0]      left_ff, left_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [AW-1:0]      rd_idx_ff, rd_idx_in;
   logic               have_ff, have_in;
   logic [CW-1:0]      pend_ff, pend_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   plis_rsp_type       rsp_ff, rsp_in;

   logic               mem_rd_en;
   logic signed [31:0] mem_rd_data;
   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic signed [31:0] mem_wr_data;

   logic [7:0]         count8;
   logic [7:0]         pos8;
   logic               issue;

   plis_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (cursor_ff[AW-1:0]),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         left_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         have_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         left_ff       <= left_in;
         rd_valid_ff   <= rd_valid_in;
         have_ff       <= have_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      value_ff  <= value_in;
      pos_ff    <= pos_in;
      cursor_ff <= cursor_in;
      rd_idx_ff <= rd_idx_in;
      pend_ff   <= pend_in;
      rsp_ff    <= rsp_in;
   end

   assign count8 = 8'(count_ff);
   assign pos8   = {1'b0, req_data.position};
   assign issue  = (state_ff == ST_RUN) && (left_ff != '0);

   // sequencer: next state, memory walk and responses
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      left_in       = left_ff;
      rd_valid_in   = 1'b0;
      rd_idx_in     = cursor_ff[AW-1:0];
      have_in       = have_ff;
      pend_in       = pend_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '{kind: KIND_OK, data: 32'sd0, last: 1'b1};
      mem_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = rd_idx_ff + AW'(1);
      mem_wr_data   = mem_rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_data.cmd;
               value_in = req_data.value;
               pos_in   = req_data.position;
               have_in  = 1'b0;
               case (req_data.cmd)
                  CMD_INSERT: begin
                     if (pos8 == 8'd0 || pos8 > count8 + 8'd1) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.kind   = KIND_BADPOS;
                     end else if (count8 == 8'(DEPTH)) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.kind   = KIND_FULL;
                     end else begin
                        state_in  = ST_RUN;
                        cursor_in = count_ff - CW'(1);
                        left_in   = CW'(count8 - pos8 + 8'd1);
                     end
                  end
                  CMD_DELETE: begin
                     if (pos8 == 8'd0 || pos8 > count8) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.kind   = KIND_BADPOS;
                     end else begin
                        state_in  = ST_RUN;
                        cursor_in = CW'(pos8);
                        left_in   = CW'(count8 - pos8);
                     end
                  end
                  CMD_SEARCH: begin
                     state_in  = ST_RUN;
                     cursor_in = '0;
                     left_in   = count_ff;
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.kind   = KIND_EMPTY;
                     end else begin
                        state_in  = ST_RUN;
                        cursor_in = '0;
                        left_in   = count_ff;
                     end
                  end
               endcase
            end
         end

         ST_RUN: begin
            // issue the next read of the walk
            if (issue) begin
               mem_rd_en   = 1'b1;
               rd_valid_in = 1'b1;
               left_in     = left_ff - CW'(1);
               if (op_ff == CMD_INSERT) begin
                  cursor_in = cursor_ff - CW'(1);
               end else begin
                  cursor_in = cursor_ff + CW'(1);
               end
            end

            // consume the read data of the previous cycle
            if (rd_valid_ff) begin
               case (op_ff)
                  CMD_INSERT: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = rd_idx_ff + AW'(1);
                  end
                  CMD_DELETE: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = rd_idx_ff - AW'(1);
                  end
                  CMD_SEARCH: begin
                     if (mem_rd_data == value_ff) begin
                        // a new match releases the one held back
                        if (have_ff) begin
                           rsp_strobe_in = 1'b1;
                           rsp_in.kind   = KIND_FOUND;
                           rsp_in.data   = 32'(pend_ff);
                           rsp_in.last   = 1'b0;
                        end
                        have_in = 1'b1;
                        pend_in = CW'(rd_idx_ff) + CW'(1);
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                     rsp_in.kind   = KIND_ELEMENT;
                     rsp_in.data   = mem_rd_data;
                     rsp_in.last   = (rd_idx_ff == AW'(count_ff - CW'(1)));
                  end
               endcase
            end

            // walk drained: finish the request
            if (!issue && !rd_valid_ff) begin
               state_in = ST_IDLE;
               case (op_ff)
                  CMD_INSERT: begin
                     mem_wr_en     = 1'b1;
                     mem_wr_addr   = AW'(pos_ff - 7'd1);
                     mem_wr_data   = value_ff;
                     count_in      = count_ff + CW'(1);
                     rsp_strobe_in = 1'b1;
                  end
                  CMD_DELETE: begin
                     count_in      = count_ff - CW'(1);
                     rsp_strobe_in = 1'b1;
                  end
                  CMD_SEARCH: begin
                     rsp_strobe_in = 1'b1;
                     if (have_ff) begin
                        rsp_in.kind = KIND_FOUND;
                        rsp_in.data = 32'(pend_ff);
                     end else begin
                        rsp_in.kind = KIND_NOTFOUND;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTHESIS
   // read data only comes back while a walk is running
   assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == ST_RUN))
      else $error("read data outside a walk");

   // the list never holds more than its capacity
   assert property (@(posedge clock) disable iff (reset)
      (32'(count_ff) <= DEPTH))
      else $error("count above capacity");

   // dump of an empty list answers empty at once
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.cmd == CMD_DUMP && count_ff == '0) |=>
         (rsp_strobe && rsp_data.kind == KIND_EMPTY && rsp_data.last && !busy))
      else $error("empty dump not answered");

   // a walk never issues a read past the memory depth
   assert property (@(posedge clock) disable iff (reset)
      issue |-> (cursor_ff < CW'(DEPTH)))
      else $error("read beyond the list");
`endif

endmodule

FILE: src/plis_ram.sv
`timescale 1ns / 1ps

module plis_ram #(
   parameter int DEPTH = plis_pkg::DEPTH_DEFAULT,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output logic signed [31:0]  rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic signed [31:0]  wr_data
);

   logic signed [31:0] mem_ff [DEPTH];
   logic signed [31:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: test/positional_list_insert_delete_search_tb.sv
`timescale 1ns / 1ps

module positional_list_insert_delete_search_tb;
   import plis_pkg::*;

   localparam int LIST_DEPTH   = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS = 450;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PRINT_CAP    = 50;

   // mirror of the list contents and the responses it owes
   class list_mirror;
      logic signed [31:0] stored[$];
      plis_rsp_type       due_responses[$];
      int                 depth;
      int                 mismatches;

      function new(int d);
         depth = d;
         mismatches = 0;
      endfunction

      function void push_response(logic [2:0] kind, logic signed [31:0] data, logic last);
         plis_rsp_type r;
         r.kind = kind;
         r.data = data;
         r.last = last;
         due_responses.push_back(r);
      endfunction

      // update the list for an accepted request and queue its responses
      function void apply_request(plis_req_type req);
         int p;
         int n;
         int hits[$];
         p = req.position;
         n = stored.size();
         case (req.cmd)
            CMD_INSERT: begin
               if (p < 1 || p > n + 1) begin
                  push_response(KIND_BADPOS, 0, 1'b1);
               end else if (n >= depth) begin
                  push_response(KIND_FULL, 0, 1'b1);
               end else begin
                  stored.insert(p - 1, req.value);
                  push_response(KIND_OK, 0, 1'b1);
               end
            end
            CMD_DELETE: begin
               if (p < 1 || p > n) begin
                  push_response(KIND_BADPOS, 0, 1'b1);
               end else begin
                  stored.delete(p - 1);
                  push_response(KIND_OK, 0, 1'b1);
               end
            end
            CMD_SEARCH: begin
               foreach (stored[i]) begin
                  if (stored[i] == req.value) hits.push_back(i + 1);
               end
               if (hits.size() == 0) begin
                  push_response(KIND_NOTFOUND, 0, 1'b1);
               end else begin
                  foreach (hits[k]) push_response(KIND_FOUND, hits[k], k == hits.size() - 1);
               end
            end
            default: begin
               if (n == 0) begin
                  push_response(KIND_EMPTY, 0, 1'b1);
               end else begin
                  foreach (stored[i]) push_response(KIND_ELEMENT, stored[i], i == n - 1);
               end
            end
         endcase
      endfunction

      task report_mismatch(string msg);
         if (mismatches < PRINT_CAP) $display("mismatch: %s", msg);
         mismatches++;
      endtask

      // compare one response with the oldest one owed
      task match_response(plis_rsp_type got);
         plis_rsp_type want;
         if (due_responses.size() == 0) begin
            report_mismatch($sformatf("response with none pending: kind %0d data %0d last %0d",
                                      got.kind, got.data, got.last));
            return;
         end
         want = due_responses.pop_front();
         if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
         if (got.data !== want.data)
            report_mismatch($sformatf("data %0d, wanted %0d (kind %0d)",
                                      got.data, want.data, want.kind));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %0d, wanted %0d (kind %0d)",
                                      got.last, want.last, want.kind));
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   plis_req_type req_data;
   logic         rsp_strobe;
   plis_rsp_type rsp_data;

   list_mirror mirror = new(LIST_DEPTH);
   int         cycle_count = 0;
   bit         growing;

   positional_list_insert_delete_search #(
      .DEPTH(LIST_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // responses are taken at the edge that ends their strobe cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe) mirror.match_response(rsp_data);
   end

   function automatic plis_req_type make_req(plis_cmd_type c, logic [31:0] v, logic [6:0] p);
      plis_req_type r;
      r.cmd = c;
      r.value = v;
      r.position = p;
      return r;
   endfunction

   // present a request and hold it until the block takes it
   task automatic send_request(input plis_req_type req);
      start <= 1'b1;
      req_data <= req;
      @(posedge clock);
      while (busy) @(posedge clock);
      mirror.apply_request(req);
   endtask

   // random request, weighted toward growing or shrinking the list
   function automatic plis_req_type pick_request(bit grow);
      int           n;
      int           roll;
      int           pos;
      int           span;
      logic [31:0]  val;
      plis_cmd_type c;
      n = mirror.stored.size();
      roll = $urandom_range(99);
      if (grow)
         c = roll < 60 ? CMD_INSERT : roll < 70 ? CMD_DELETE : roll < 85 ? CMD_SEARCH : CMD_DUMP;
      else
         c = roll < 15 ? CMD_INSERT : roll < 70 ? CMD_DELETE : roll < 85 ? CMD_SEARCH : CMD_DUMP;
      // small pool of values so that searches find duplicates
      case ($urandom_range(4))
         0:       val = 32'h8000_0000;
         1:       val = 32'h7fff_ffff;
         2:       val = $urandom_range(3);
         default: val = $urandom;
      endcase
      if (c == CMD_SEARCH && n > 0 && $urandom_range(1)) val = mirror.stored[$urandom_range(n - 1)];
      // mostly in-range positions, with both ends favored
      span = (c == CMD_INSERT) ? n + 1 : n;
      roll = $urandom_range(9);
      if (c == CMD_SEARCH || c == CMD_DUMP) pos = $urandom_range(127);
      else if (roll == 0) pos = 0;
      else if (roll == 1 || span == 0) pos = $urandom_range(127, span + 1);
      else if (roll == 2) pos = span;
      else if (roll == 3) pos = 1;
      else pos = $urandom_range(span, 1);
      return make_req(c, val, pos[6:0]);
   endfunction

   // stimulus
   initial begin
      int burst_left;
      int gap;
      int n;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      growing = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list, range errors, both ends, duplicates
      send_request(make_req(CMD_DUMP,   $urandom, 7'd0));
      send_request(make_req(CMD_SEARCH, 32'd0, 7'd127));
      send_request(make_req(CMD_DELETE, $urandom, 7'd1));
      send_request(make_req(CMD_DELETE, $urandom, 7'd0));
      send_request(make_req(CMD_INSERT, 32'd5, 7'd0));
      send_request(make_req(CMD_INSERT, 32'd5, 7'd2));
      send_request(make_req(CMD_INSERT, 32'h7fff_ffff, 7'd1));
      send_request(make_req(CMD_INSERT, 32'h8000_0000, 7'd2));
      send_request(make_req(CMD_INSERT, 32'hffff_ffff, 7'd1));
      send_request(make_req(CMD_INSERT, 32'd0, 7'd2));
      send_request(make_req(CMD_INSERT, 32'h7fff_ffff, 7'd5));
      send_request(make_req(CMD_INSERT, 32'd9, 7'd7));
      send_request(make_req(CMD_INSERT, 32'd9, 7'd127));
      send_request(make_req(CMD_SEARCH, 32'h7fff_ffff, 7'd0));
      send_request(make_req(CMD_SEARCH, 32'd12345, 7'd3));
      send_request(make_req(CMD_DUMP,   $urandom, 7'd127));
      send_request(make_req(CMD_DELETE, $urandom, 7'd5));
      send_request(make_req(CMD_DELETE, $urandom, 7'd5));
      send_request(make_req(CMD_DELETE, $urandom, 7'd127));
      send_request(make_req(CMD_DELETE, $urandom, 7'd1));
      send_request(make_req(CMD_DELETE, $urandom, 7'd2));
      send_request(make_req(CMD_DUMP,   $urandom, 7'd0));
      send_request(make_req(CMD_SEARCH, 32'h8000_0000, 7'd0));

      // random: fill toward full, drain toward empty, in bursts
      burst_left = $urandom_range(16, 1);
      for (int item = 0; item < RANDOM_ITEMS; item++) begin
         n = mirror.stored.size();
         if (n == LIST_DEPTH && $urandom_range(3) == 0) growing = 1'b0;
         else if (n == 0 && $urandom_range(3) == 0) growing = 1'b1;
         else if ($urandom_range(39) == 0) growing = !growing;
         send_request(pick_request(growing));
         burst_left--;
         if (burst_left == 0) begin
            gap = $urandom_range(2) == 0 ? 0 : $urandom_range(8, 1);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = $urandom_range(16, 1);
         end
      end
      start <= 1'b0;

      // drain outstanding responses, then watch for strays
      while (mirror.due_responses.size() != 0) @(posedge clock);
      repeat (LIST_DEPTH + 8) @(posedge clock);
      if (mirror.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
